>>> hdl/page_framebuffer_sprite_blitter_assert.svh
// Assertion macros used by the sprite blitter controller (pfsb_ctrl).
// Each macro expects signals named clk and rst in the including scope.
`ifndef PAGE_FRAMEBUFFER_SPRITE_BLITTER_ASSERT_SVH
`define PAGE_FRAMEBUFFER_SPRITE_BLITTER_ASSERT_SVH

// Property that must hold on every clock edge outside reset
`define PFSB_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked in the same cycle
`define PFSB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle
`define PFSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pfsb_pkg.sv
// Shared types and constants for the page frame store sprite blitter.
// No dependencies; imported by every module of the block except pfsb_ram.
package pfsb_pkg;

  // Frame geometry
  localparam int SCREEN_COLUMNS = 128;
  localparam int STORE_BYTES    = 1024;
  localparam int PAGE_ROWS      = 8;
  localparam int PAGE_SHIFT     = $clog2(PAGE_ROWS);
  localparam int PAGE_COUNT     = STORE_BYTES / SCREEN_COLUMNS;
  localparam int ADDR_W         = $clog2(STORE_BYTES);

  // Signed working width for column and row arithmetic
  localparam int POS_W = 12;

  // Sprite cursor limits
  localparam int WIDTH_MAX  = 128;
  localparam int ROW_LIMIT  = 240;
  localparam int ROW_SAT    = 248;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BEGIN = 2'd1,
    OP_BYTE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RD_LO,
    ST_WR_LO,
    ST_WR_HI,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // input beat accepted this cycle
    logic sweep_run;  // write zero at sweep address and step it
    logic rd_lo;      // read the upper-page byte
    logic rmw_lo;     // write upper page, read lower page
    logic rmw_hi;     // write lower page
    logic load;       // load the result register
  } pfsb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
  } pfsb_stat_t;

endpackage

>>> hdl/pfsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/pfsb_ctrl.sv
// Sequencer for the sprite blitter: clear sweeps, read-modify-write steps, result hand-off.
// Depends on pfsb_pkg and the assertion macro header.
`include "page_framebuffer_sprite_blitter_assert.svh"

module pfsb_ctrl
  import pfsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  output logic       out_valid,
  input  logic       out_stall,
  output pfsb_cmd_t  cmd,
  input  pfsb_stat_t stat
);

  state_t state, state_next;
  logic   out_valid_next;
  op_t    op_in;

  assign op_in = op_t'(op);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_INIT: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (op_in)
            OP_CLEAR: state_next = ST_CLEAR;
            OP_BYTE:  state_next = ST_RD_LO;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_RD_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = ST_WR_LO;
      end
      ST_WR_LO: begin
        cmd.rmw_lo = 1'b1;
        state_next = ST_WR_HI;
      end
      ST_WR_HI: begin
        cmd.rmw_hi = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // Result register occupancy
  always_comb begin
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `PFSB_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
  `PFSB_ASSERT_SAME(a_no_take_in_sweep, (state == ST_INIT) || (state == ST_CLEAR), in_stall, "input taken during clear sweep")
  `PFSB_ASSERT_SAME(a_load_slot_free, cmd.load, !(out_valid && out_stall), "result loaded over a waiting beat")
  `PFSB_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken before first finished")
  `PFSB_ASSERT_NEXT(a_rmw_order, cmd.rd_lo, cmd.rmw_lo, "upper page read not followed by its write")

endmodule

>>> hdl/pfsb_dp.sv
// Datapath for the sprite blitter: cursor registers, placement math, frame store and result.
// Depends on pfsb_pkg and pfsb_ram.
module pfsb_dp
  import pfsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  pfsb_cmd_t  cmd,
  output pfsb_stat_t stat,
  input  logic [1:0] op,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [7:0] sprite_width,
  input  logic       wrap,
  input  logic [7:0] pixel_byte,
  input  logic [9:0] read_index,
  output logic [7:0] read_data,
  output logic       clipped
);

  op_t op_in;
  assign op_in = op_t'(op);

  // Sprite cursor
  logic [7:0] origin_x;
  logic [7:0] origin_y;
  logic [7:0] cur_width;
  logic       cur_wrap;
  logic [6:0] col_count;
  logic [7:0] row_advance;

  // Per-item work registers
  logic [ADDR_W-1:0] lo_addr_q, hi_addr_q;
  logic [7:0]        lo_part_q, hi_part_q;
  logic              lo_en_q, hi_en_q;
  logic              res_clip, res_rd_ok;
  logic [ADDR_W-1:0] sweep_cnt;

  // Placement
  logic signed [POS_W-1:0] col_raw, col_fix, row, pg, pg_hi;
  logic                    col_bad, lo_ok, hi_ok, byte_nz, lo_nz, hi_nz;
  logic [15:0]             spread;
  logic [7:0]              lo_part, hi_part;
  logic [ADDR_W-1:0]       lo_addr, hi_addr;
  logic [7:0]              col_inc;
  logic [7:0]              width_sat;

  // RAM ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_q;

  // Column with optional wrap and clipping
  always_comb begin
    col_raw = POS_W'($signed(origin_x)) + $signed(POS_W'(col_count));
    if (col_raw[POS_W-1]) begin
      col_fix = col_raw + $signed(POS_W'(SCREEN_COLUMNS));
    end else begin
      col_fix = col_raw;
    end
    col_bad = (col_raw[POS_W-1] && !cur_wrap) || col_fix[POS_W-1]
              || (int'(col_fix) >= SCREEN_COLUMNS);
  end

  // Row to floor page and bit offset
  always_comb begin
    row     = POS_W'($signed(origin_y)) + $signed(POS_W'(row_advance));
    pg      = row >>> PAGE_SHIFT;
    pg_hi   = pg + $signed(POS_W'(1));
    spread  = 16'(pixel_byte) << row[PAGE_SHIFT-1:0];
    lo_part = spread[7:0];
    hi_part = spread[15:8];
    byte_nz = (pixel_byte != 8'd0);
    lo_nz   = (lo_part != 8'd0);
    hi_nz   = (hi_part != 8'd0);
    lo_ok   = !pg[POS_W-1] && (int'(pg) < PAGE_COUNT);
    hi_ok   = !pg_hi[POS_W-1] && (int'(pg_hi) < PAGE_COUNT);
    lo_addr = ADDR_W'(int'(pg) * SCREEN_COLUMNS + int'(col_fix));
    hi_addr = ADDR_W'(int'(pg_hi) * SCREEN_COLUMNS + int'(col_fix));
  end

  // Cursor step and width saturation
  assign col_inc = {1'b0, col_count} + 8'd1;

  always_comb begin
    if (sprite_width == 8'd0) begin
      width_sat = 8'd1;
    end else if (int'(sprite_width) > WIDTH_MAX) begin
      width_sat = 8'(WIDTH_MAX);
    end else begin
      width_sat = sprite_width;
    end
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= 8'd0;
      origin_y    <= 8'd0;
      cur_width   <= 8'd1;
      cur_wrap    <= 1'b0;
      col_count   <= 7'd0;
      row_advance <= 8'd0;
    end else if (cmd.take) begin
      case (op_in)
        OP_BEGIN: begin
          origin_x    <= pos_x;
          origin_y    <= pos_y;
          cur_width   <= width_sat;
          cur_wrap    <= wrap;
          col_count   <= 7'd0;
          row_advance <= 8'd0;
        end
        OP_BYTE: begin
          if (col_inc >= cur_width) begin
            col_count <= 7'd0;
            if (int'(row_advance) <= ROW_LIMIT) begin
              row_advance <= row_advance + 8'(PAGE_ROWS);
            end else begin
              row_advance <= 8'(ROW_SAT);
            end
          end else begin
            col_count <= col_inc[6:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Latch the work for the accepted item
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lo_addr_q <= lo_addr;
      hi_addr_q <= hi_addr;
      lo_part_q <= lo_part;
      hi_part_q <= hi_part;
      lo_en_q   <= (op_in == OP_BYTE) && byte_nz && !col_bad && lo_nz && lo_ok;
      hi_en_q   <= (op_in == OP_BYTE) && byte_nz && !col_bad && hi_nz && hi_ok;
      res_clip  <= (op_in == OP_BYTE) && byte_nz
                   && (col_bad || (lo_nz && !lo_ok) || (hi_nz && !hi_ok));
      res_rd_ok <= (op_in == OP_READ) && (int'(read_index) < STORE_BYTES);
    end
  end

  // Clear sweep address
  assign stat.sweep_last = (sweep_cnt == ADDR_W'(STORE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_run) begin
      sweep_cnt <= stat.sweep_last ? '0 : sweep_cnt + ADDR_W'(1);
    end
  end

  // Frame store port steering
  always_comb begin
    ram_we    = cmd.sweep_run || (cmd.rmw_lo && lo_en_q) || (cmd.rmw_hi && hi_en_q);
    ram_waddr = cmd.sweep_run ? sweep_cnt : (cmd.rmw_lo ? lo_addr_q : hi_addr_q);
    ram_wdata = cmd.sweep_run ? 8'd0 : (ram_q | (cmd.rmw_lo ? lo_part_q : hi_part_q));
    ram_re    = (cmd.take && (op_in == OP_READ)) || cmd.rd_lo || cmd.rmw_lo;
    ram_raddr = cmd.take ? ADDR_W'(read_index) : (cmd.rd_lo ? lo_addr_q : hi_addr_q);
  end

  pfsb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_data <= res_rd_ok ? ram_q : 8'd0;
      clipped   <= res_clip;
    end
  end

endmodule

>>> hdl/page_framebuffer_sprite_blitter.sv
// Page frame store sprite blitter, top level. One item is handled at a time.
// From accept to result beat: begin and read pass to ST_DONE; a sprite byte passes
// ST_RD_LO, ST_WR_LO, ST_WR_HI, ST_DONE (read-modify-write of two pages through the
// store's one read port and one write port); clear runs ST_CLEAR, one store byte
// zeroed per cycle, then ST_DONE. ST_DONE waits while out_stall holds a result beat.
// Items are taken only in ST_IDLE. Reset: sweeps the store to zero with in_stall high.
module page_framebuffer_sprite_blitter
  import pfsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [7:0] sprite_width,
  input  logic       wrap,
  input  logic [7:0] pixel_byte,
  input  logic [9:0] read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       clipped
);

  pfsb_cmd_t  cmd;
  pfsb_stat_t stat;

  pfsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  pfsb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .sprite_width (sprite_width),
    .wrap         (wrap),
    .pixel_byte   (pixel_byte),
    .read_index   (read_index),
    .read_data    (read_data),
    .clipped      (clipped)
  );

endmodule

>>> dv/blit_check_pkg.sv
// Frame store tracker for the sprite blitter testbench: predicts each result beat
// and checks the block's results in order. Depends on pfsb_pkg for geometry and op codes.
`timescale 1ns / 1ps

package blit_check_pkg;
  import pfsb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       clip;
  } blit_reply_t;

  class frame_tracker;
    bit [7:0]    pixels [STORE_BYTES];
    bit [7:0]    org_x;
    bit [7:0]    org_y;
    bit [7:0]    span;
    bit          wrap_on;
    bit [6:0]    col_step;
    bit [7:0]    row_step;
    blit_reply_t replies_due [$];
    int          last_index;
    int          mismatches;

    function new();
      foreach (pixels[i]) pixels[i] = 8'd0;
      org_x      = 8'd0;
      org_y      = 8'd0;
      span       = 8'd1;
      wrap_on    = 1'b0;
      col_step   = 7'd0;
      row_step   = 8'd0;
      last_index = 0;
      mismatches = 0;
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
    endtask

    // OR one part into a page; returns 1 when set bits land off screen
    function bit or_into_page(int pg, int col, bit [7:0] part);
      int idx;
      if (part == 8'd0) return 1'b0;
      if (pg < 0 || pg >= PAGE_COUNT) return 1'b1;
      idx = pg * SCREEN_COLUMNS + col;
      pixels[idx] |= part;
      last_index = idx;
      return 1'b0;
    endfunction

    // Place one sprite byte at the cursor; returns the clip flag
    function bit blit_clip(bit [7:0] data);
      int       col;
      int       row;
      int       off;
      int       pg;
      bit       lost;
      bit [7:0] lo_part;
      bit [7:0] hi_part;
      col = $signed(org_x) + $signed({1'b0, col_step});
      row = $signed(org_y) + $signed({1'b0, row_step});
      if (data == 8'd0) return 1'b0;
      // negative column: wrap by screen width or drop
      if (col < 0) begin
        if (!wrap_on) return 1'b1;
        col += SCREEN_COLUMNS;
        if (col < 0) return 1'b1;
      end
      if (col >= SCREEN_COLUMNS) return 1'b1;
      // floor paging, so rows above the screen land in negative pages
      off     = row & (PAGE_ROWS - 1);
      pg      = row >>> PAGE_SHIFT;
      lo_part = data << off;
      hi_part = data >> (PAGE_ROWS - off);
      lost    = or_into_page(pg, col, lo_part);
      if (off != 0) lost = lost | or_into_page(pg + 1, col, hi_part);
      return lost;
    endfunction

    // Accepted input beat: update the shadow state and queue its result
    task take_item(op_t kind, logic [7:0] px, logic [7:0] py, logic [7:0] wd, logic wr,
                   logic [7:0] pb, logic [9:0] ri);
      blit_reply_t due;
      int          next_col;
      due = '0;
      case (kind)
        OP_CLEAR: begin
          foreach (pixels[i]) pixels[i] = 8'd0;
        end
        OP_BEGIN: begin
          org_x    = px;
          org_y    = py;
          span     = (wd == 8'd0) ? 8'd1 : ((wd > WIDTH_MAX) ? 8'(WIDTH_MAX) : wd);
          wrap_on  = wr;
          col_step = 7'd0;
          row_step = 8'd0;
        end
        OP_BYTE: begin
          due.clip = blit_clip(pb);
          next_col = col_step + 1;
          if (next_col >= span) begin
            col_step = 7'd0;
            // row cursor saturates instead of wrapping
            row_step = (row_step <= ROW_LIMIT) ? row_step + 8'(PAGE_ROWS) : 8'(ROW_SAT);
          end else begin
            col_step = 7'(next_col);
          end
        end
        OP_READ: begin
          due.data = (ri < STORE_BYTES) ? pixels[ri] : 8'd0;
        end
        default: ;
      endcase
      replies_due.push_back(due);
    endtask

    // Accepted result beat: compare with the oldest prediction
    task check_reply(logic [7:0] data, logic clip);
      blit_reply_t due;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected result read_data=%02h clipped=%b", data, clip));
        return;
      end
      due = replies_due.pop_front();
      if (data !== due.data)
        report($sformatf("read_data got %02h want %02h", data, due.data));
      if (clip !== due.clip)
        report($sformatf("clipped got %b want %b", clip, due.clip));
    endtask
  endclass

endpackage

>>> dv/tb_page_framebuffer_sprite_blitter.sv
// Testbench top for page_framebuffer_sprite_blitter: directed and random sprite traffic
// under varying idle and stall pressure. Depends on pfsb_pkg and blit_check_pkg.
`timescale 1ns / 1ps

module tb_page_framebuffer_sprite_blitter;
  import pfsb_pkg::*;
  import blit_check_pkg::*;

  localparam int ITEM_TARGET  = 1700;
  localparam int PHASE_ITEMS  = 150;
  localparam int IDLE_LIMIT   = 6000;
  localparam int DRAIN_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] op;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] sprite_width;
  logic       wrap;
  logic [7:0] pixel_byte;
  logic [9:0] read_index;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       clipped;

  frame_tracker sb;
  int           sent;
  int           phase;
  int           tx_idle_pct;
  int           rx_stall_pct;
  int           quiet;

  page_framebuffer_sprite_blitter uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= (rx_stall_pct > 0) && ($urandom_range(0, 99) < rx_stall_pct);
  end

  // result check, input capture and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (out_valid && !out_stall) sb.check_reply(read_data, clipped);
      if (in_valid && !in_stall)
        sb.take_item(op_t'(op), pos_x, pos_y, sprite_width, wrap, pixel_byte, read_index);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet = 0;
      else quiet = quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("page_framebuffer_sprite_blitter regression: fail");
        $finish;
      end
    end
  end

  // One input beat; entered and left at a falling edge
  task automatic send_item(op_t kind, logic [7:0] px, logic [7:0] py, logic [7:0] wd,
                           logic wr, logic [7:0] pb, logic [9:0] ri);
    // phase change: hold off until every result is back, then switch idling and stall pressure
    if (sent / PHASE_ITEMS != phase) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (sb.replies_due.size() != 0) @(negedge clk);
      phase = sent / PHASE_ITEMS;
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    pos_x        <= px;
    pos_y        <= py;
    sprite_width <= wd;
    wrap         <= wr;
    pixel_byte   <= pb;
    read_index   <= ri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // unused fields carry random values
  task automatic send_begin(logic [7:0] px, logic [7:0] py, logic [7:0] wd, logic wr);
    send_item(OP_BEGIN, px, py, wd, wr, 8'($urandom), 10'($urandom));
  endtask

  task automatic send_byte(logic [7:0] pb);
    send_item(OP_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), pb,
              10'($urandom));
  endtask

  task automatic send_read(logic [9:0] ri);
    send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
              8'($urandom), ri);
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
              8'($urandom), 10'($urandom));
  endtask

  // One sprite: begin then its bytes, with read-backs of freshly written bytes
  task automatic run_sprite();
    int         style;
    int         rows;
    int         span;
    int         count;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] sw;
    style = $urandom_range(0, 9);
    rows  = $urandom_range(1, 4);
    if (style < 6) begin
      // mostly on screen, straddling the edges
      sx = 8'($urandom_range(0, 143) - 8);
      sy = 8'($urandom_range(0, 79) - 8);
      sw = 8'($urandom_range(1, 12));
    end else if (style < 9) begin
      sx = 8'($urandom);
      sy = 8'($urandom);
      sw = 8'($urandom);
    end else begin
      // tall and narrow: drives the row cursor into saturation
      sx   = 8'($urandom_range(0, 127));
      sy   = 8'($urandom_range(0, 191) - 128);
      sw   = 8'($urandom_range(0, 2));
      rows = $urandom_range(32, 36);
    end
    span  = (sw == 8'd0) ? 1 : ((sw > WIDTH_MAX) ? WIDTH_MAX : sw);
    count = span * rows;
    if (count > 80) count = $urandom_range(16, 80);
    send_begin(sx, sy, sw, 1'($urandom));
    repeat (count) begin
      send_byte(($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom));
      if ($urandom_range(0, 3) == 0)
        send_read(10'(sb.last_index + ($urandom_range(0, 1) ? SCREEN_COLUMNS : 0)));
    end
  endtask

  initial begin
    int pick;
    sb           = new();
    sent         = 0;
    phase        = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_CLEAR;
    pos_x        = 8'd0;
    pos_y        = 8'd0;
    sprite_width = 8'd0;
    wrap         = 1'b0;
    pixel_byte   = 8'd0;
    read_index   = 10'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty store at both ends of the index range
    send_read(10'd0);
    send_read(10'h3FF);
    // plain byte at the origin
    send_begin(8'd0, 8'd0, 8'd1, 1'b0);
    send_byte(8'hFF);
    send_read(10'd0);
    // last column, row below the screen
    send_begin(8'h7F, 8'h7F, 8'h80, 1'b1);
    send_byte(8'h81);
    // most negative origin, width zero saturates to one
    send_begin(8'h80, 8'h80, 8'h00, 1'b1);
    send_byte(8'hA5);
    // wrapped column, byte split over two pages, width saturates
    send_begin(8'hFF, 8'h03, 8'hFF, 1'b1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h3C);
    send_read(10'd127);
    send_read(10'd255);
    // negative column without wrap, then a row above the screen
    send_begin(8'hFF, 8'hFD, 8'h02, 1'b0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_read(10'd0);
    // last column, then one past the screen width
    send_begin(8'h7F, 8'd60, 8'd16, 1'b0);
    send_byte(8'hF0);
    send_byte(8'h0F);
    send_read(10'h3FF);
    send_clear();
    send_read(10'h3FF);

    // random traffic, mostly whole sprites
    while (sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_clear();
      end else if (pick < 12) begin
        send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 8'($urandom), 10'($urandom));
      end else if (pick < 20) begin
        send_read(10'($urandom));
      end else begin
        run_sprite();
      end
    end

    // drain
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.replies_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0)
      $display("page_framebuffer_sprite_blitter regression: pass");
    else
      $display("page_framebuffer_sprite_blitter regression: fail");
    $finish;
  end

endmodule
